// ===== src/nfes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfes_pkg
// Shared types and constants of the nearest free entry search block.
// ----------------------------------------------------------------------------
package nfes_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CELL_BITS   = 10;

  localparam int ENTRY_W   = 6;
  localparam int CELL_IN_W = 10;
  localparam int WORKER_W  = 19;
  localparam int FRAC_BITS = 8;
  localparam int DIST_W    = 23;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CELL_W = (CELL_BITS < CELL_IN_W) ? CELL_BITS : CELL_IN_W;
  localparam int WC_W   = WORKER_W - FRAC_BITS;
  localparam int DX_W   = WC_W + 1;
  localparam int SQ_W   = 2 * DX_W - 2;
  localparam int MEM_W  = 2 * CELL_W + 1;

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             wr;
    logic             query;
    logic             issue;
    logic             last;
    logic [IDX_W-1:0] addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ctrl_status_t;

endpackage

// ===== src/nfes_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfes_ctrl
// Sequencer: accepts beats, steps the scan address and marks the result.
// ----------------------------------------------------------------------------
module nfes_ctrl
  import nfes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         cmd_in,
  input  ctrl_status_t status,
  output logic         busy,
  output logic         done,
  output ctrl_cmd_t    ctrl
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic             accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd_in) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == LAST_ADDR) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.scan_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (accept && cmd_in) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    done       = 1'b0;
    ctrl.issue = 1'b0;
    case (state)
      ST_IDLE:  ;
      ST_SCAN: begin
        busy       = 1'b1;
        ctrl.issue = 1'b1;
      end
      ST_DRAIN: busy = 1'b1;
      ST_DONE:  done = 1'b1;
      default:  busy = 1'b0;
    endcase
    ctrl.wr    = accept && !cmd_in;
    ctrl.query = accept && cmd_in;
    ctrl.last  = (cnt == LAST_ADDR);
    ctrl.addr  = cnt;
  end

endmodule

// ===== src/nfes_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfes_datapath
// Entry table, distance pipeline and running minimum of the search.
// ----------------------------------------------------------------------------
module nfes_datapath
  import nfes_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_cmd_t                   ctrl,
  input  logic [ENTRY_W-1:0]          entry_index,
  input  logic [CELL_IN_W-1:0]        cell_x,
  input  logic [CELL_IN_W-1:0]        cell_y,
  input  logic                        taken,
  input  logic                        in_use,
  input  logic signed [WORKER_W-1:0]  worker_x,
  input  logic signed [WORKER_W-1:0]  worker_y,
  output ctrl_status_t                status,
  output logic                        found,
  output logic [ENTRY_W-1:0]          best_index,
  output logic [DIST_W-1:0]           best_distance
);

  logic [MEM_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] used;
  logic [IDX_W-1:0]       waddr;
  logic                   in_range;

  logic signed [WC_W-1:0] wx;
  logic signed [WC_W-1:0] wy;

  logic [MEM_W-1:0]       s1_rd;
  logic                   s1_vld;
  logic                   s1_used;
  logic                   s1_last;
  logic [IDX_W-1:0]       s1_idx;

  logic [SQ_W-1:0]        s2_sqx;
  logic [SQ_W-1:0]        s2_sqy;
  logic                   s2_cand;
  logic                   s2_last;
  logic [IDX_W-1:0]       s2_idx;

  logic [IDX_W-1:0]       best_idx;
  logic [DIST_W-1:0]      sq_sum;

  logic [CELL_W-1:0]          s1_x;
  logic [CELL_W-1:0]          s1_y;
  logic                       s1_taken;
  logic signed [DX_W-1:0]     dx;
  logic signed [DX_W-1:0]     dy;
  logic signed [2*DX_W-1:0]   px;
  logic signed [2*DX_W-1:0]   py;

  assign waddr    = IDX_W'(entry_index);
  assign in_range = (32'(entry_index) < 32'(TABLE_DEPTH));

  // entry table
  always_ff @(posedge clk) begin
    if (ctrl.wr && in_range) begin
      mem[waddr] <= {taken, CELL_W'(cell_y), CELL_W'(cell_x)};
    end
    s1_rd <= mem[ctrl.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctrl.wr && in_range) begin
      used[waddr] <= in_use;
    end
  end

  // worker position in whole cells
  always_ff @(posedge clk) begin
    if (ctrl.query) begin
      wx <= worker_x[WORKER_W-1:FRAC_BITS];
      wy <= worker_y[WORKER_W-1:FRAC_BITS];
    end
  end

  assign s1_x     = s1_rd[CELL_W-1:0];
  assign s1_y     = s1_rd[2*CELL_W-1:CELL_W];
  assign s1_taken = s1_rd[MEM_W-1];

  assign dx = DX_W'(wx) - DX_W'($signed({1'b0, s1_x}));
  assign dy = DX_W'(wy) - DX_W'($signed({1'b0, s1_y}));
  assign px = dx * dx;
  assign py = dy * dy;

  assign sq_sum = DIST_W'(s2_sqx) + DIST_W'(s2_sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
      s2_cand <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      s1_vld  <= ctrl.issue;
      s1_last <= ctrl.issue && ctrl.last;
      s2_cand <= s1_vld && s1_used && !s1_taken;
      s2_last <= s1_vld && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_used <= used[ctrl.addr];
    s1_idx  <= ctrl.addr;
    s2_sqx  <= px[SQ_W-1:0];
    s2_sqy  <= py[SQ_W-1:0];
    s2_idx  <= s1_idx;
  end

  // running minimum, first entry wins a tie
  always_ff @(posedge clk) begin
    if (rst || ctrl.query) begin
      found         <= 1'b0;
      best_idx      <= '0;
      best_distance <= '0;
    end else if (s2_cand && (!found || sq_sum < best_distance)) begin
      found         <= 1'b1;
      best_idx      <= s2_idx;
      best_distance <= sq_sum;
    end
  end

  assign best_index       = ENTRY_W'(best_idx);
  assign status.scan_done = s2_last;

endmodule

// ===== src/nearest_free_entry_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_free_entry_search
// Table of job entries with a nearest used, untaken entry query.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; cmd picks a table
// write (cmd low) or a query (cmd high). A write stores one entry at the
// accept edge, gives no result and leaves busy low, so beats may follow
// every cycle. A query raises busy and scans the table one entry per
// cycle through the single read port of the entry memory, then a
// three-stage distance pipeline drains. done is high for exactly one
// cycle; the result on found, best_index and best_distance is valid then
// and holds until the next query is accepted. busy is low in the done
// cycle, so the next query may be accepted at the edge that takes the
// result; a new query is not taken before the last one has finished.
// The receiver cannot hold results off; done is a plain strobe.
// Reset marks every table entry unused and returns the block to idle at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_free_entry_search
  import nfes_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [ENTRY_W-1:0]          entry_index,
  input  logic [CELL_IN_W-1:0]        cell_x,
  input  logic [CELL_IN_W-1:0]        cell_y,
  input  logic                        taken,
  input  logic                        in_use,
  input  logic signed [WORKER_W-1:0]  worker_x,
  input  logic signed [WORKER_W-1:0]  worker_y,
  output logic                        done,
  output logic                        found,
  output logic [ENTRY_W-1:0]          best_index,
  output logic [DIST_W-1:0]           best_distance
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  nfes_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd_in (cmd),
    .status (status),
    .busy   (busy),
    .done   (done),
    .ctrl   (ctrl)
  );

  nfes_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .entry_index   (entry_index),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .taken         (taken),
    .in_use        (in_use),
    .worker_x      (worker_x),
    .worker_y      (worker_y),
    .status        (status),
    .found         (found),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> busy)
    else $error("query accepted without busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result held longer than one cycle");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    !found |-> (best_index == '0 && best_distance == '0))
    else $error("nonzero result fields without a found entry");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    status.scan_done |-> busy)
    else $error("scan end seen while idle");
`endif

endmodule
